[rtl/core/rfl_pkg.sv]
// shared constants, codes and control types of the reflectance array line classifier
package rfl_pkg;

   // defaults of the top-level parameters
   localparam int SENSOR_COUNT_DEF = 6;
   localparam int TIMER_BITS_DEF   = 16;

   // payload widths
   localparam int OPCODE_W    = 1;
   localparam int COUNTER_W   = 16;
   localparam int PINS_W      = 6;
   localparam int INDEX_W     = 3;
   localparam int CAL_W       = 16;
   localparam int CLASS_W     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // arithmetic widths of the calibration path
   localparam int T_W    = 21;  // signed 9*raw + black - 10*white
   localparam int DEN_SW = 17;  // signed black - white
   localparam int MAG_W  = 26;  // magnitude of 100 * t
   localparam int DEN_W  = 16;  // magnitude of black - white

   localparam int RAW_GAIN    = 9;
   localparam int WHITE_GAIN  = 10;
   localparam int SCALE_GAIN  = 100;
   localparam int SAT_POS     = 32767;
   localparam int SAT_NEG_MAG = 32768;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_START  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

   // line classes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LINE = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_STOP = 2'd2;

   // register map
   localparam int                    CAL_REGS     = 6;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESH  = 3'd7;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] CAL_RESET     = 32'd65536000;
   localparam logic [COUNTER_W-1:0]  TIMEOUT_RESET = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] THRESH_RESET  = 32'd52428920;

   typedef struct packed {
      logic capture_start;
      logic capture_sample;
      logic index_clear;
      logic index_next;
      logic load;
      logic scale;
      logic div_start;
      logic finish;
   } rfl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic last_sensor;
      logic div_busy;
   } rfl_status_type;

endpackage

[rtl/core/rfl_req_if.sv]
// input channel: scan start and pin sample transactions
interface rfl_req_if
   import rfl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [COUNTER_W-1:0] counter_value;
   logic [PINS_W-1:0]    pin_levels;

   modport source (output valid, output opcode, output counter_value, output pin_levels,
                   input ready);
   modport sink   (input valid, input opcode, input counter_value, input pin_levels,
                   output ready);
endinterface

[rtl/core/rfl_rsp_if.sv]
// result channel: one classified reading per sensor
interface rfl_rsp_if
   import rfl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [INDEX_W-1:0]      sensor_index;
   logic [COUNTER_W-1:0]    raw_time;
   logic signed [CAL_W-1:0] calibrated;
   logic [CLASS_W-1:0]      line_class;
   logic                    last;

   modport source (output valid, output sensor_index, output raw_time, output calibrated,
                   output line_class, output last, input ready);
   modport sink   (input valid, input sensor_index, input raw_time, input calibrated,
                   input line_class, input last, output ready);
endinterface

[rtl/core/rfl_csr.sv]
// configuration registers: per-sensor calibration, timeout and class thresholds
module rfl_csr
   import rfl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic [INDEX_W-1:0]     cal_index,
   output logic [CSR_DATA_W-1:0]  cal_sel,
   output logic [COUNTER_W-1:0]   timeout_limit,
   output logic [CSR_DATA_W-1:0]  class_thresholds
);

   logic [CSR_DATA_W-1:0] cal_ff [CAL_REGS];
   logic [COUNTER_W-1:0]  timeout_ff;
   logic [CSR_DATA_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CAL_REGS; i++) begin
            cal_ff[i] <= CAL_RESET;
         end
         timeout_ff <= TIMEOUT_RESET;
         thresh_ff  <= THRESH_RESET;
      end else if (csr_write_enable) begin
         if (csr_index < CSR_INDEX_W'(CAL_REGS)) begin
            cal_ff[csr_index] <= csr_write_data;
         end else if (csr_index == REG_TIMEOUT) begin
            timeout_ff <= csr_write_data[COUNTER_W-1:0];
         end else if (csr_index == REG_THRESH) begin
            thresh_ff <= csr_write_data;
         end
      end
   end

   // sensors without a register keep the reset calibration
   assign cal_sel = (cal_index < INDEX_W'(CAL_REGS)) ? cal_ff[cal_index] : CAL_RESET;
   assign timeout_limit    = timeout_ff;
   assign class_thresholds = thresh_ff;

endmodule

[rtl/core/rfl_div.sv]
// restoring divider on magnitudes, one quotient bit per cycle
module rfl_div
   import rfl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [MAG_W-1:0] quotient,
   output logic             busy
);

   localparam int STEP_W = $clog2(MAG_W);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[MAG_W-1]};
      trial   = shifted - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = STEP_W'(MAG_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, divisor}) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;

endmodule

[rtl/core/rfl_datapath.sv]
// capture registers, calibration arithmetic, classification and result register
module rfl_datapath
   import rfl_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
   parameter int TIMER_BITS   = TIMER_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  rfl_cmd_type             cmd,
   output rfl_status_type          status,
   input  logic [COUNTER_W-1:0]    counter_value,
   input  logic [PINS_W-1:0]       pin_levels,
   input  logic [COUNTER_W-1:0]    timeout_limit,
   input  logic [CSR_DATA_W-1:0]   class_thresholds,
   input  logic [CSR_DATA_W-1:0]   cal_sel,
   output logic [INDEX_W-1:0]      cal_index,
   output logic [INDEX_W-1:0]      sensor_index,
   output logic [COUNTER_W-1:0]    raw_time,
   output logic signed [CAL_W-1:0] calibrated,
   output logic [CLASS_W-1:0]      line_class,
   output logic                    last
);

   localparam int CAP_W = (TIMER_BITS < COUNTER_W) ? TIMER_BITS : COUNTER_W;
   localparam int SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   logic [SENSOR_COUNT-1:0] pin_vec;
   logic [COUNTER_W-1:0]    cnt_masked;

   logic [CAP_W-1:0] capture_ff [SENSOR_COUNT];
   logic [CAP_W-1:0] capture_in [SENSOR_COUNT];
   logic [SEL_W-1:0] idx_ff, idx_in;

   logic [COUNTER_W-1:0]     raw_cur;
   logic [COUNTER_W-1:0]     white, black;
   logic [T_W-1:0]           pos_sum, neg_sum;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic signed [DEN_SW-1:0] den_ff, den_in;
   logic [COUNTER_W-1:0]     raw_hold_ff;

   logic [T_W-2:0]       t_abs;
   logic [DEN_W-1:0]     den_abs;
   logic [MAG_W-1:0]     num_mag_ff, num_mag_in;
   logic [DEN_W-1:0]     den_mag_ff;
   logic                 neg_ff, den_zero_ff;

   logic [MAG_W-1:0]        quotient;
   logic                    div_busy;
   logic signed [CAL_W-1:0] cal_in;
   logic signed [CAL_W:0]   cal_wide, line_wide, stop_wide;
   logic [CLASS_W-1:0]      class_in;

   logic [INDEX_W-1:0]      index_out_ff;
   logic [COUNTER_W-1:0]    raw_out_ff;
   logic signed [CAL_W-1:0] cal_out_ff;
   logic [CLASS_W-1:0]      class_out_ff;
   logic                    last_out_ff;

   // sensors beyond the pin field read low
   for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_pin
      if (g < PINS_W) begin : g_real
         assign pin_vec[g] = pin_levels[g];
      end else begin : g_none
         assign pin_vec[g] = 1'b0;
      end
   end

   assign cnt_masked = COUNTER_W'(counter_value[CAP_W-1:0]);

   assign status.scan_done   = (pin_vec == '0) || (cnt_masked > timeout_limit);
   assign status.last_sensor = (idx_ff == SEL_W'(SENSOR_COUNT - 1));
   assign status.div_busy    = div_busy;

   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         capture_in[i] = capture_ff[i];
         if (cmd.capture_start || (cmd.capture_sample && pin_vec[i])) begin
            capture_in[i] = counter_value[CAP_W-1:0];
         end
      end
      idx_in = idx_ff;
      if (cmd.index_clear) begin
         idx_in = '0;
      end else if (cmd.index_next) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            capture_ff[i] <= '0;
         end
         idx_ff <= '0;
      end else begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            capture_ff[i] <= capture_in[i];
         end
         idx_ff <= idx_in;
      end
   end

   assign cal_index = INDEX_W'(idx_ff);

   // load: 9*raw + black - 10*white and black - white
   always_comb begin
      raw_cur = COUNTER_W'(capture_ff[idx_ff]);
      white   = cal_sel[COUNTER_W-1:0];
      black   = cal_sel[CSR_DATA_W-1:COUNTER_W];
      pos_sum = T_W'(raw_cur) * T_W'(RAW_GAIN) + T_W'(black);
      neg_sum = T_W'(white) * T_W'(WHITE_GAIN);
      t_in    = signed'(pos_sum - neg_sum);
      den_in  = signed'(DEN_SW'(black) - DEN_SW'(white));
   end

   // scale: magnitudes and signs for the divider
   always_comb begin
      t_abs      = (T_W-1)'(t_ff[T_W-1] ? (~t_ff + 1'b1) : t_ff);
      den_abs    = DEN_W'(den_ff[DEN_SW-1] ? (~den_ff + 1'b1) : den_ff);
      num_mag_in = MAG_W'(t_abs) * MAG_W'(SCALE_GAIN);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff        <= t_in;
         den_ff      <= den_in;
         raw_hold_ff <= raw_cur;
      end
      if (cmd.scale) begin
         num_mag_ff  <= num_mag_in;
         den_mag_ff  <= den_abs;
         neg_ff      <= t_ff[T_W-1] ^ den_ff[DEN_SW-1];
         den_zero_ff <= (den_ff == '0);
      end
   end

   rfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_mag_ff),
      .divisor  (den_mag_ff),
      .quotient (quotient),
      .busy     (div_busy)
   );

   // finish: sign, saturation and class
   always_comb begin
      if (den_zero_ff) begin
         cal_in = '0;
      end else if (!neg_ff) begin
         cal_in = (quotient > MAG_W'(SAT_POS)) ? CAL_W'(SAT_POS) : CAL_W'(quotient);
      end else begin
         cal_in = (quotient > MAG_W'(SAT_NEG_MAG)) ? CAL_W'(SAT_NEG_MAG)
                                                  : CAL_W'(MAG_W'(0) - quotient);
      end
      cal_wide  = {cal_in[CAL_W-1], cal_in};
      line_wide = signed'({1'b0, class_thresholds[COUNTER_W-1:0]});
      stop_wide = signed'({1'b0, class_thresholds[CSR_DATA_W-1:COUNTER_W]});
      if (cal_wide > stop_wide) begin
         class_in = CLASS_STOP;
      end else if (cal_wide > line_wide) begin
         class_in = CLASS_LINE;
      end else begin
         class_in = CLASS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         index_out_ff <= INDEX_W'(idx_ff);
         raw_out_ff   <= raw_hold_ff;
         cal_out_ff   <= cal_in;
         class_out_ff <= class_in;
         last_out_ff  <= status.last_sensor;
      end
   end

   assign sensor_index = index_out_ff;
   assign raw_time     = raw_out_ff;
   assign calibrated   = cal_out_ff;
   assign line_class   = class_out_ff;
   assign last         = last_out_ff;

endmodule

[rtl/core/rfl_ctrl.sv]
// scan and calibration sequencer
module rfl_ctrl
   import rfl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rfl_cmd_type         cmd,
   input  rfl_status_type      status
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ARMED    = 3'd1;
   localparam logic [2:0] ST_LOAD     = 3'd2;
   localparam logic [2:0] ST_SCALE    = 3'd3;
   localparam logic [2:0] ST_DIV_GO   = 3'd4;
   localparam logic [2:0] ST_DIV_WAIT = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;
   localparam logic [2:0] ST_EMIT     = 3'd7;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff) inside
         ST_IDLE, ST_ARMED: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_START) begin
                  cmd.capture_start = 1'b1;
                  state_in          = ST_ARMED;
               end else if (state_ff == ST_ARMED) begin
                  cmd.capture_sample = 1'b1;
                  if (status.scan_done) begin
                     cmd.index_clear = 1'b1;
                     state_in        = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last_sensor) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.index_next = 1'b1;
                  state_in       = ST_LOAD;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider restarted while busy");

   a_scan_end_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ARMED && req_valid && req_opcode == OP_SAMPLE && status.scan_done)
      |=> !req_ready)
      else $error("input still open after the scan finished");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && status.last_sensor) |=> req_ready)
      else $error("input not reopened after the final result");
`endif

endmodule

[rtl/core/reflectance_array_line_classifier_unit.sv]
// top level of the reflectance array line classifier
//
//  channel  direction  handshake            payload
//  req_ch   in         valid/ready          opcode, counter_value, pin_levels
//  rsp_ch   out        valid/ready          sensor_index, raw_time, calibrated,
//                                           line_class, last
//  csr_*    in         write enable only    csr_index, csr_write_data
//
// a start or sample transaction is taken back to back outside a pass
// the finishing sample runs one pass per sensor: load, scale, divider start,
// divider wait (the 26-bit quotient, then the done check), finish, emit
// req_ch.ready stays low for that pass; a stalled result holds in its register
// reset restores the register defaults, clears the captures and disarms the scan
module reflectance_array_line_classifier_unit
   import rfl_pkg::*;
#(
   parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
   parameter int TIMER_BITS   = TIMER_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   rfl_req_if.sink                req_ch,
   rfl_rsp_if.source              rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   rfl_cmd_type           cmd;
   rfl_status_type        status;
   logic [INDEX_W-1:0]    cal_index;
   logic [CSR_DATA_W-1:0] cal_sel;
   logic [COUNTER_W-1:0]  timeout_limit;
   logic [CSR_DATA_W-1:0] class_thresholds;

   // register file, read by the datapath one sensor at a time
   rfl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cal_index        (cal_index),
      .cal_sel          (cal_sel),
      .timeout_limit    (timeout_limit),
      .class_thresholds (class_thresholds)
   );

   // sequencer owns both handshakes
   rfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd),
      .status     (status)
   );

   // captures, calibration, divider and the result register
   rfl_datapath #(
      .SENSOR_COUNT (SENSOR_COUNT),
      .TIMER_BITS   (TIMER_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .counter_value    (req_ch.counter_value),
      .pin_levels       (req_ch.pin_levels),
      .timeout_limit    (timeout_limit),
      .class_thresholds (class_thresholds),
      .cal_sel          (cal_sel),
      .cal_index        (cal_index),
      .sensor_index     (rsp_ch.sensor_index),
      .raw_time         (rsp_ch.raw_time),
      .calibrated       (rsp_ch.calibrated),
      .line_class       (rsp_ch.line_class),
      .last             (rsp_ch.last)
   );

endmodule

[sim/tb_reflectance_array_line_classifier_unit.sv]
// self-checking testbench of the reflectance array line classifier unit
module tb_reflectance_array_line_classifier_unit;
   import rfl_pkg::*;

   localparam int NUM_SENSORS   = SENSOR_COUNT_DEF;
   localparam int RANDOM_ITEMS  = 460;
   localparam int NUM_PHASES    = 7;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES  = 250;
   localparam int MAX_SAMPLES   = 10;
   localparam longint WATCHDOG  = 64'd8_000_000;

   // calibration words that push the quotient into saturation or odd signs
   localparam logic [CSR_DATA_W-1:0] SAT_CAL_WORDS [NUM_SENSORS] = '{
      32'h0001_0000, 32'h0000_0001, 32'h0000_FFFF,
      32'hFFFF_0000, 32'hFFFE_FFFF, 32'h0001_0002
   };

   // one classified reading as it leaves the block
   typedef struct packed {
      logic [INDEX_W-1:0]      sensor_index;
      logic [COUNTER_W-1:0]    raw_time;
      logic signed [CAL_W-1:0] calibrated;
      logic [CLASS_W-1:0]      line_class;
      logic                    last;
   } reading_type;

   // keeps its own copy of the registers and scan state, predicts the readings
   // of every finishing sample and matches them against the result channel
   class reading_scoreboard_type;
      logic [CSR_DATA_W-1:0] cal_word [NUM_SENSORS];
      logic [COUNTER_W-1:0]  timeout_limit;
      logic [CSR_DATA_W-1:0] thresholds;
      logic [COUNTER_W-1:0]  capture [NUM_SENSORS];
      bit                    armed;
      reading_type           expected_readings [$];
      int                    failures;

      function new();
         foreach (cal_word[i]) begin
            cal_word[i] = CAL_RESET;
            capture[i]  = '0;
         end
         timeout_limit = TIMEOUT_RESET;
         thresholds    = THRESH_RESET;
         armed         = 1'b0;
         failures      = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx < CAL_REGS) begin
            cal_word[idx] = data;
         end else if (idx == REG_TIMEOUT) begin
            timeout_limit = data[COUNTER_W-1:0];
         end else if (idx == REG_THRESH) begin
            thresholds = data;
         end
      endfunction

      // 100*(9*raw + black - 10*white)/(black - white), truncated and saturated
      function longint calibrate(logic [COUNTER_W-1:0] raw, logic [CSR_DATA_W-1:0] word);
         longint white, black, span, q;
         white = longint'(word[15:0]);
         black = longint'(word[31:16]);
         span  = black - white;
         if (span == 0) return 0;
         q = (SCALE_GAIN * (RAW_GAIN * longint'(raw) + black - WHITE_GAIN * white)) / span;
         if (q > SAT_POS) q = SAT_POS;
         if (q < -SAT_NEG_MAG) q = -SAT_NEG_MAG;
         return q;
      endfunction

      function logic [CLASS_W-1:0] classify(longint level);
         if (level > longint'(thresholds[31:16])) return CLASS_STOP;
         if (level > longint'(thresholds[15:0])) return CLASS_LINE;
         return CLASS_NONE;
      endfunction

      // returns 0 for a sample that the idle block ignores
      function bit note_input(logic [OPCODE_W-1:0] op, logic [COUNTER_W-1:0] cnt,
                              logic [PINS_W-1:0] pins);
         reading_type r;
         longint      level;
         if (op == OP_START) begin
            foreach (capture[i]) capture[i] = cnt;
            armed = 1'b1;
            return 1'b1;
         end
         if (!armed) return 1'b0;
         foreach (capture[i]) begin
            if (pins[i]) capture[i] = cnt;
         end
         if (pins != '0 && cnt <= timeout_limit) return 1'b1;
         armed = 1'b0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            level          = calibrate(capture[i], cal_word[i]);
            r.sensor_index = INDEX_W'(i);
            r.raw_time     = capture[i];
            r.calibrated   = CAL_W'(level);
            r.line_class   = classify(level);
            r.last         = (i == NUM_SENSORS - 1);
            expected_readings.push_back(r);
         end
         return 1'b1;
      endfunction

      function void check_result(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            $error("unexpected reading for sensor %0d, raw %0d", got.sensor_index, got.raw_time);
            failures++;
            return;
         end
         want = expected_readings.pop_front();
         if (got.sensor_index !== want.sensor_index) begin
            $error("sensor_index: expected %0d, got %0d", want.sensor_index, got.sensor_index);
            failures++;
         end
         if (got.raw_time !== want.raw_time) begin
            $error("raw_time: expected %0d, got %0d", want.raw_time, got.raw_time);
            failures++;
         end
         if (got.calibrated !== want.calibrated) begin
            $error("calibrated: expected %0d, got %0d", want.calibrated, got.calibrated);
            failures++;
         end
         if (got.line_class !== want.line_class) begin
            $error("line_class: expected %0d, got %0d", want.line_class, got.line_class);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   rfl_req_if req_ch();
   rfl_rsp_if rsp_ch();

   reading_scoreboard_type sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int accepted_items = 0;

   reflectance_array_line_classifier_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure, sampled at the same edges as the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every transaction on the result channel goes through the scoreboard
   always @(posedge clock) begin
      reading_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.sensor_index = rsp_ch.sensor_index;
         got.raw_time     = rsp_ch.raw_time;
         got.calibrated   = rsp_ch.calibrated;
         got.line_class   = rsp_ch.line_class;
         got.last         = rsp_ch.last;
         sb.check_result(got);
      end
   end

   // idle mix moves with the run: sender light / receiver heavy, then swapped, then none
   function void pick_idling();
      if (accepted_items < RANDOM_ITEMS / 3) begin
         send_idle_pct = 15;
         recv_idle_pct = 55;
      end else if (accepted_items < 2 * RANDOM_ITEMS / 3) begin
         send_idle_pct = 55;
         recv_idle_pct = 15;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endfunction

   // valid stays high after a transaction so back-to-back items need no extra edge
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [COUNTER_W-1:0] cnt,
                            input logic [PINS_W-1:0] pins);
      pick_idling();
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.counter_value <= cnt;
      req_ch.pin_levels    <= pins;
      do @(posedge clock); while (!req_ch.ready);
      if (sb.note_input(op, cnt, pins)) accepted_items++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every reading, then let the block go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] typical_cal();
      logic [15:0] white;
      white = 16'($urandom_range(400));
      case ($urandom_range(7))
         0: return {white, white};
         1: return {white, 16'(white + $urandom_range(1, 2000))};
         2: return $urandom;
         default: return {16'(white + $urandom_range(1, 3000)), white};
      endcase
   endfunction

   task automatic configure_phase(input int phase);
      logic [15:0] line_th;
      for (int s = 0; s < CAL_REGS; s++) begin
         case (phase)
            2: csr_write(CSR_INDEX_W'(s), '0);                  // black equals white
            3: csr_write(CSR_INDEX_W'(s), SAT_CAL_WORDS[s]);
            5: csr_write(CSR_INDEX_W'(s), '1);                  // black equals white, all ones
            default: csr_write(CSR_INDEX_W'(s), typical_cal());
         endcase
      end
      line_th = 16'($urandom_range(50, 400));
      case (phase)
         2: begin
            csr_write(REG_TIMEOUT, '0);
            csr_write(REG_THRESH, '0);
         end
         3: begin
            csr_write(REG_TIMEOUT, CSR_DATA_W'($urandom_range(65535)));
            csr_write(REG_THRESH, $urandom);
         end
         5: begin
            csr_write(REG_TIMEOUT, CSR_DATA_W'(16'hFFFF));
            csr_write(REG_THRESH, '1);
         end
         default: begin
            csr_write(REG_TIMEOUT, CSR_DATA_W'($urandom_range(300, 5000)));
            csr_write(REG_THRESH, {16'(line_th + $urandom_range(0, 1500)), line_th});
         end
      endcase
   endtask

   // a well-formed scan: start, then non-decreasing counts with pins dropping out, now and then restarted
   task automatic run_scan();
      logic [COUNTER_W-1:0] cnt;
      logic [PINS_W-1:0]    pins;
      int                   step_max;
      int                   n;
      int                   next;
      step_max = (sb.timeout_limit > 12) ? int'(sb.timeout_limit) / 3 : 4;
      cnt = ($urandom_range(9) == 0) ? COUNTER_W'($urandom) : COUNTER_W'($urandom_range(200));
      send_item(OP_START, cnt, PINS_W'($urandom));
      pins = ($urandom_range(1) == 0) ? '1 : PINS_W'($urandom);
      n = 0;
      while (sb.armed) begin
         if ($urandom_range(19) == 0) begin
            // restart in the middle of a scan
            cnt = COUNTER_W'($urandom_range(500));
            send_item(OP_START, cnt, PINS_W'($urandom));
         end
         next = int'(cnt) + (($urandom_range(9) == 0) ? 0 : $urandom_range(1, step_max));
         cnt  = (next > 65535) ? '1 : COUNTER_W'(next);
         if (n >= MAX_SAMPLES) pins = '0;
         send_item(OP_SAMPLE, cnt, pins);
         pins = pins & PINS_W'($urandom | $urandom);
         n++;
      end
   endtask

   initial begin
      int target;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= OP_START;
      req_ch.counter_value <= '0;
      req_ch.pin_levels    <= '0;
      csr_write_enable     <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset calibration: white 0, black 1000, timeout 1000
      send_item(OP_SAMPLE, '1, '1);                    // sample while idle, ignored
      send_item(OP_START, '0, '0);
      send_item(OP_SAMPLE, 16'd10, 6'h3F);
      send_item(OP_SAMPLE, 16'd200, 6'h2A);            // odd sensors reach the line class
      send_item(OP_SAMPLE, 16'd900, '0);               // all pins low ends the scan
      send_item(OP_START, 16'd100, 6'h15);
      send_item(OP_START, 16'd50, 6'h2A);              // restart while armed
      send_item(OP_SAMPLE, 16'd1001, 6'h3F);           // just past the timeout
      send_item(OP_START, '1, '1);
      send_item(OP_SAMPLE, '1, 6'h15);                 // maximum count, saturates to stop
      send_item(OP_START, '0, '1);
      send_item(OP_SAMPLE, '0, '0);                    // zero raw time everywhere
      send_item(OP_START, 16'd1000, '0);
      send_item(OP_SAMPLE, 16'd1000, 6'h3F);           // equal to the timeout, keeps going
      send_item(OP_SAMPLE, 16'd400, 6'h01);
      send_item(OP_SAMPLE, 16'd12, '0);
      settle();

      // random part over a series of register settings
      target = accepted_items;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) configure_phase(phase);
         target += RANDOM_ITEMS / NUM_PHASES;
         while (accepted_items < target) begin
            if ($urandom_range(99) < 80) begin
               run_scan();
            end else begin
               send_item(OPCODE_W'($urandom), COUNTER_W'($urandom), PINS_W'($urandom));
            end
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb_reflectance_array_line_classifier_unit: PASS");
      end else begin
         $display("tb_reflectance_array_line_classifier_unit: FAIL");
      end
      $finish;
   end

   initial begin
      #(WATCHDOG);
      $display("tb_reflectance_array_line_classifier_unit: FAIL");
      $finish;
   end

endmodule
